/* src/cole_pkg.sv */
// Shared types and codes for the circular ordered list engine.
// Depends on nothing; the top, datapath, controller and checker import it.
`timescale 1ns / 1ps
`default_nettype none

package cole_pkg;

   // Default number of list slots.
   localparam int DEFAULT_CAPACITY = 16;

   // Fixed field widths of the stream beats.
   localparam int REQ_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [1:0]          rd_sel_type;

   // Request codes.
   localparam req_code_type REQ_FRONT  = 3'd0;
   localparam req_code_type REQ_END    = 3'd1;
   localparam req_code_type REQ_AFTER  = 3'd2;
   localparam req_code_type REQ_DELETE = 3'd3;
   localparam req_code_type REQ_READ   = 3'd4;

   // Result status codes.
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   // Read address selection for the element and link memories.
   localparam rd_sel_type RD_CUR  = 2'd0;
   localparam rd_sel_type RD_TAIL = 2'd1;
   localparam rd_sel_type RD_LINK = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      rd_sel_type rd_sel;
      logic       walk_first;
      logic       walk_next;
      logic       new_write;
      logic       new_self;
      logic       fix_write;
      logic       start_commit;
      logic       del_commit;
      logic       set_status;
      status_type status;
      logic       emit_elem;
      logic       emit_status;
   } cole_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      req_code_type req;
      logic         empty;
      logic         full;
      logic         key_match;
      logic         last_step;
      logic         out_free;
   } cole_stat_type;

endpackage

`default_nettype wire

/* src/circular_ordered_list_engine_top.sv */
// Circular ordered list engine. Insert front/end writes the new element after the tail and
// links it, or starts an empty list with it. A read-out gives one result beat per element,
// held while stalled. Delete and insert-after walk from the head to the matching key;
// insert-after then links its element; refused and unused requests give only a status beat.
// Synchronous reset empties the list; memory contents are left as they are.
// Depends on cole_pkg, cole_ctrl and cole_datapath.
`timescale 1ns / 1ps
`default_nettype none

module circular_ordered_list_engine_top #(
   parameter int CAPACITY = cole_pkg::DEFAULT_CAPACITY
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire [63:0]                    req_tdata,  // value[31:0], key[63:32]
   input  wire [cole_pkg::REQ_W-1:0]     req_tuser,  // req_type[2:0]
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [39:0]                   rsp_tdata,  // element[31:0], count[38:32], zero[39]
   output logic [cole_pkg::STATUS_W-1:0] rsp_tuser,  // status[1:0]
   output logic                          rsp_tlast   // last_of_run
);

   import cole_pkg::*;

   cole_cmd_type  cmd;
   cole_stat_type stat;

   cole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_req     (req_tuser),
      .in_value   (req_tdata[31:0]),
      .in_key     (req_tdata[63:32]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* src/cole_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* src/cole_datapath.sv */
// Datapath of the list engine: element and link memories, list pointers,
// free slot map and the result beat register. Depends on cole_pkg, cole_ram.
`timescale 1ns / 1ps
`default_nettype none

module cole_datapath #(
   parameter int CAPACITY = cole_pkg::DEFAULT_CAPACITY
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire [cole_pkg::REQ_W-1:0]     in_req,
   input  wire [cole_pkg::VALUE_W-1:0]   in_value,
   input  wire [cole_pkg::VALUE_W-1:0]   in_key,
   input  cole_pkg::cole_cmd_type        cmd,
   output cole_pkg::cole_stat_type       stat,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [39:0]                   rsp_tdata,
   output logic [cole_pkg::STATUS_W-1:0] rsp_tuser,
   output logic                          rsp_tlast
);

   import cole_pkg::*;

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Request registers.
   req_code_type              type_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] key_ff;

   // List state.
   logic [SW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   logic [SW-1:0]       lowest_free_ff, lowest_free_in;

   // Walk registers.
   logic [SW-1:0] cur_ff, cur_in;
   logic [SW-1:0] prev_ff, prev_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] fix_ff, fix_in;
   status_type    status_ff, status_in;

   // Result beat register.
   logic                 out_valid_ff, out_valid_in;
   status_type           out_status_ff;
   logic [VALUE_W-1:0]   out_elem_ff;
   logic                 out_last_ff;
   logic [COUNT_W-1:0]   out_count_ff;

   // Memory ports.
   logic [SW-1:0]      rd_addr;
   logic [VALUE_W-1:0] elem_rd;
   logic [SW-1:0]      link_rd;
   logic               elem_we;
   logic               link_we;
   logic [SW-1:0]      link_waddr;
   logic [SW-1:0]      link_wdata;

   logic emit;
   logic single;

   assign single = (count_ff == CW'(1));
   assign emit   = cmd.emit_elem | cmd.emit_status;

   // Memory read address selection.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_TAIL: rd_addr = tail_ff;
         RD_LINK: rd_addr = link_rd;
         default: rd_addr = cur_ff;
      endcase
   end

   // Memory write ports; new elements always take the lowest free slot.
   always_comb begin
      elem_we    = cmd.new_write;
      link_we    = 1'b0;
      link_waddr = lowest_free_ff;
      link_wdata = link_rd;
      if (cmd.new_write) begin
         link_we    = 1'b1;
         link_wdata = cmd.new_self ? lowest_free_ff : link_rd;
      end else if (cmd.fix_write) begin
         link_we    = 1'b1;
         link_waddr = fix_ff;
         link_wdata = lowest_free_ff;
      end else if (cmd.del_commit && !single) begin
         link_we    = 1'b1;
         link_waddr = prev_ff;
      end
   end

   cole_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (lowest_free_ff),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (elem_rd)
   );

   cole_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   // Lowest free slot, found from the free map and registered.
   always_comb begin
      lowest_free_in = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            lowest_free_in = SW'(i);
         end
      end
   end

   // List pointer, count and free map updates.
   always_comb begin
      tail_in  = tail_ff;
      count_in = count_ff;
      free_in  = free_ff;
      if (cmd.start_commit) begin
         tail_in                 = lowest_free_ff;
         count_in                = CW'(1);
         free_in[lowest_free_ff] = 1'b0;
      end else if (cmd.fix_write) begin
         count_in                = count_ff + CW'(1);
         free_in[lowest_free_ff] = 1'b0;
         if ((type_ff == REQ_END) || ((type_ff == REQ_AFTER) && (fix_ff == tail_ff))) begin
            tail_in = lowest_free_ff;
         end
      end else if (cmd.del_commit) begin
         count_in        = count_ff - CW'(1);
         free_in[cur_ff] = 1'b1;
         if (single) begin
            tail_in = '0;
         end else if (cur_ff == tail_ff) begin
            tail_in = prev_ff;
         end
      end
   end

   // Walk pointers and the pending status.
   always_comb begin
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      idx_in    = idx_ff;
      fix_in    = fix_ff;
      status_in = status_ff;
      if (cmd.walk_first) begin
         cur_in  = link_rd;
         prev_in = tail_ff;
         idx_in  = '0;
      end else if (cmd.walk_next) begin
         cur_in  = link_rd;
         prev_in = cur_ff;
         idx_in  = idx_ff + SW'(1);
      end
      if (cmd.new_write) begin
         fix_in = (type_ff == REQ_AFTER) ? cur_ff : tail_ff;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
   end

   // Result beat valid: set on load, cleared when taken.
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= '0;
         count_ff     <= '0;
         free_ff      <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lowest_free_ff <= lowest_free_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      idx_ff         <= idx_in;
      fix_ff         <= fix_in;
      status_ff      <= status_in;
      if (cmd.accept) begin
         type_ff  <= in_req;
         value_ff <= in_value;
         key_ff   <= in_key;
      end
      if (cmd.emit_elem) begin
         out_status_ff <= ST_OK;
         out_elem_ff   <= elem_rd;
         out_last_ff   <= stat.last_step;
         out_count_ff  <= COUNT_W'(count_ff);
      end else if (cmd.emit_status) begin
         out_status_ff <= status_ff;
         out_elem_ff   <= '0;
         out_last_ff   <= 1'b1;
         out_count_ff  <= COUNT_W'(count_ff);
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.req       = type_ff;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.key_match = (elem_rd == key_ff);
      stat.last_step = ((CW'(idx_ff) + CW'(1)) == count_ff);
      stat.out_free  = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_count_ff, out_elem_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* src/cole_ctrl.sv */
// Controller state machine of the list engine: decodes each request and
// sequences the datapath through the list walk. Depends on cole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cole_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  cole_pkg::cole_stat_type  stat,
   output cole_pkg::cole_cmd_type   cmd
);

   import cole_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_HEAD     = 3'd2;
   localparam logic [2:0] S_FIRST    = 3'd3;
   localparam logic [2:0] S_WALK     = 3'd4;
   localparam logic [2:0] S_FIX      = 3'd5;
   localparam logic [2:0] S_RESULT   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_CUR;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in       = S_RESULT;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            unique case (stat.req) inside
               REQ_FRONT, REQ_END: begin
                  if (stat.empty) begin
                     cmd.new_write    = 1'b1;
                     cmd.new_self     = 1'b1;
                     cmd.start_commit = 1'b1;
                  end else if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
               REQ_AFTER: begin
                  if (stat.empty) begin
                     cmd.status = ST_EMPTY;
                  end else if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
               REQ_DELETE, REQ_READ: begin
                  if (stat.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
               default: begin
                  cmd.status = ST_OK;
               end
            endcase
         end
         S_HEAD: begin
            // Fetch the successor of the tail, which is the head.
            cmd.rd_sel = RD_TAIL;
            state_in   = S_FIRST;
         end
         S_FIRST: begin
            if ((stat.req == REQ_FRONT) || (stat.req == REQ_END)) begin
               cmd.new_write = 1'b1;
               state_in      = S_FIX;
            end else begin
               cmd.walk_first = 1'b1;
               cmd.rd_sel     = RD_LINK;
               state_in       = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.req == REQ_READ) begin
               // One result beat per element; hold the read while stalled.
               if (stat.out_free) begin
                  cmd.emit_elem = 1'b1;
                  cmd.walk_next = 1'b1;
                  cmd.rd_sel    = RD_LINK;
                  if (stat.last_step) begin
                     state_in = S_IDLE;
                  end
               end
            end else if (stat.key_match) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
               if (stat.req == REQ_AFTER) begin
                  cmd.new_write = 1'b1;
                  state_in      = S_FIX;
               end else begin
                  cmd.del_commit = 1'b1;
                  state_in       = S_RESULT;
               end
            end else if (stat.last_step) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_RESULT;
            end else begin
               cmd.walk_next = 1'b1;
               cmd.rd_sel    = RD_LINK;
            end
         end
         S_FIX: begin
            // Point the predecessor at the new element.
            cmd.fix_write  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_in       = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* src/cole_checker.sv */
// Port-level checks for the circular ordered list engine, bound to the top.
// Depends on cole_pkg and circular_ordered_list_engine_top.
`timescale 1ns / 1ps
`default_nettype none

module cole_checker #(
   parameter int CAPACITY = cole_pkg::DEFAULT_CAPACITY
) (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_tvalid,
   input wire                           rsp_tready,
   input wire [39:0]                    rsp_tdata,
   input wire [cole_pkg::STATUS_W-1:0]  rsp_tuser,
   input wire                           rsp_tlast
);

   import cole_pkg::*;

   // A stalled result beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A beat with an error status carries no element and ends its run.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[31:0] == '0) && rsp_tlast)
      else $error("error status beat with element or without last");

   // The count never exceeds the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[38:32] <= 7'(CAPACITY)))
      else $error("count above capacity");

   // A full status is only reported when every slot is taken.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |-> (rsp_tdata[38:32] == 7'(CAPACITY)))
      else $error("full status with free slots");

   // An empty status is only reported for an empty list.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> (rsp_tdata[38:32] == '0))
      else $error("empty status with elements held");

endmodule

bind circular_ordered_list_engine_top cole_checker #(
   .CAPACITY (CAPACITY)
) u_cole_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
